// File: rtl/ssh_pkg.sv
package ssh_pkg;

  localparam int MAX_SAMPLES = 512;
  localparam int HIST_BINS   = 32;

  localparam int KIND_W = 3;
  localparam int VAL_W  = 8;
  localparam int IDX_W  = 9;
  localparam int CNT_W  = 10;
  localparam int SUM_W  = 17;
  localparam int POS_W  = $clog2(MAX_SAMPLES);
  localparam int BIN_W  = $clog2(HIST_BINS);

  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [VAL_W-1:0] BASE_RESET = VAL_W'(10);
  localparam logic [VAL_W-1:0] MIN_RESET  = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 3'd0,
    KIND_SUMMARY = 3'd1,
    KIND_BIN     = 3'd2,
    KIND_ELEMENT = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_RANGE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_INDEX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [VAL_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  stored_position;
    logic [VAL_W-1:0]  element_value;
    logic              is_odd;
    logic              below_mean;
    logic [VAL_W-1:0]  mean_value;
    logic [VAL_W-1:0]  minimum;
    logic [VAL_W-1:0]  maximum;
    logic [CNT_W-1:0]  even_total;
    logic [CNT_W-1:0]  odd_total;
    logic [CNT_W-1:0]  sample_total;
    logic [CNT_W-1:0]  bin_count;
  } res_t;

endpackage

// File: rtl/ssh_if.sv
interface ssh_in_if;
  import ssh_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, output kind, output value, output index, input ready);
  modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface ssh_out_if;
  import ssh_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [POS_W-1:0] stored_position;
  logic [VAL_W-1:0] element_value;
  logic             is_odd;
  logic             below_mean;
  logic [VAL_W-1:0] mean_value;
  logic [VAL_W-1:0] minimum;
  logic [VAL_W-1:0] maximum;
  logic [CNT_W-1:0] even_total;
  logic [CNT_W-1:0] odd_total;
  logic [CNT_W-1:0] sample_total;
  logic [CNT_W-1:0] bin_count;

  modport source (
    output valid, output status, output stored_position, output element_value,
    output is_odd, output below_mean, output mean_value, output minimum,
    output maximum, output even_total, output odd_total, output sample_total,
    output bin_count, input ready
  );
  modport sink (
    input valid, input status, input stored_position, input element_value,
    input is_odd, input below_mean, input mean_value, input minimum,
    input maximum, input even_total, input odd_total, input sample_total,
    input bin_count, output ready
  );
endinterface

interface ssh_cfg_if;
  import ssh_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ssh_ram.sv
module ssh_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ssh_div.sv
module ssh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssh_pkg::div_req_t  req_i,
  output ssh_pkg::div_rsp_t  rsp_o
);
  import ssh_pkg::*;

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_STEPS);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q && (cnt_q != '0)) begin
      // shift in one dividend bit, subtract when the divisor fits
      cnt_d = cnt_q - DCNT_W'(1);
      if (fits) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q[VAL_W-1:0];

endmodule

// File: rtl/sample_statistics_histogram.sv
// Statistics engine over a set of byte samples with a histogram.
// Channels: in_i (kind, value, index), out_o (one result word per input word),
// cfg_i (base_value, the sample mapped to histogram bin zero). All use
// valid/ready; a word moves on a rising edge with both high. cfg_i is always
// ready. The user must write it only while idle; the block does not enforce it.
// Flow: an accepted word is worked on in S_EXEC. Samples, bin queries, clears
// and rejected queries then load their result into the output register in
// S_RESP. Summary and element queries on a non-empty set (element: valid index)
// first run the bit-serial divider for sum / count, 17 steps, in S_DIV. The
// block takes one word at a time, the next one back in S_IDLE.
// Results sit in an output register; a stalled receiver holds that word
// stable while the next input word is taken and worked on, and the block then
// waits until the register frees up.
// Reset empties the set, zeroes the histogram, sets minimum to 255, maximum
// to 0 and base_value to 10. Sample store contents are undefined until
// written; only written positions are ever returned.
module sample_statistics_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssh_in_if.sink      in_i,
  ssh_cfg_if.sink     cfg_i,
  ssh_out_if.source   out_o
);
  import ssh_pkg::*;

  state_e            state_q, state_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [IDX_W-1:0]  index_q, index_d;

  logic [VAL_W-1:0]  base_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  even_q, even_d;
  logic [CNT_W-1:0]  odd_q, odd_d;
  logic [VAL_W-1:0]  min_q, min_d;
  logic [VAL_W-1:0]  max_q, max_d;
  logic [CNT_W-1:0]  hist_q [HIST_BINS];
  logic [CNT_W-1:0]  hist_d [HIST_BINS];

  res_t              res_q, res_d;
  logic              need_below_q, need_below_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [VAL_W-1:0]  diff;
  logic              in_range;
  logic              full;
  logic              bin_ok;
  logic              elem_ok;
  logic [BIN_W-1:0]  hist_addr;
  logic [CNT_W-1:0]  hist_rd;

  logic              ram_we;
  logic              ram_re;
  logic [VAL_W-1:0]  ram_rdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign diff      = value_q - base_q;
  assign in_range  = (value_q >= base_q) && ({1'b0, diff} < (VAL_W + 1)'(HIST_BINS));
  assign full      = count_q >= CNT_W'(MAX_SAMPLES);
  assign bin_ok    = {1'b0, index_q} < (IDX_W + 1)'(HIST_BINS);
  assign elem_ok   = {1'b0, index_q} < count_q;
  assign hist_addr = (kind_q == KIND_SAMPLE) ? diff[BIN_W-1:0] : index_q[BIN_W-1:0];
  assign hist_rd   = hist_q[hist_addr];

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    value_d      = value_q;
    index_d      = index_q;
    count_d      = count_q;
    sum_d        = sum_q;
    even_d       = even_q;
    odd_d        = odd_q;
    min_d        = min_q;
    max_d        = max_q;
    hist_d       = hist_q;
    res_d        = res_q;
    need_below_d = need_below_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q;
    div_req.divisor  = count_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = in_i.kind;
          value_d = in_i.value;
          index_d = in_i.index;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d        = '0;
        need_below_d = 1'b0;
        state_d      = S_RESP;
        unique case (kind_q)
          KIND_SAMPLE: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
              sum_d   = sum_q + SUM_W'(value_q);
              if (value_q < min_q) begin
                min_d = value_q;
              end
              if (value_q > max_q) begin
                max_d = value_q;
              end
              if (value_q[0]) begin
                odd_d = odd_q + CNT_W'(1);
              end else begin
                even_d = even_q + CNT_W'(1);
              end
              if (in_range) begin
                hist_d[hist_addr] = hist_rd + CNT_W'(1);
              end else begin
                res_d.status = ST_RANGE;
              end
              res_d.stored_position = count_q[POS_W-1:0];
              res_d.is_odd          = value_q[0];
            end
          end
          KIND_SUMMARY: begin
            res_d.minimum      = min_q;
            res_d.maximum      = max_q;
            res_d.even_total   = even_q;
            res_d.odd_total    = odd_q;
            res_d.sample_total = count_q;
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
          KIND_BIN: begin
            if (bin_ok) begin
              res_d.bin_count = hist_rd;
            end else begin
              res_d.status = ST_INDEX;
            end
          end
          KIND_ELEMENT: begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
            end else if (!elem_ok) begin
              res_d.status = ST_INDEX;
            end else begin
              ram_re        = 1'b1;
              need_below_d  = 1'b1;
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
          KIND_CLEAR: begin
            count_d = '0;
            sum_d   = '0;
            even_d  = '0;
            odd_d   = '0;
            min_d   = MIN_RESET;
            max_d   = '0;
            for (int b = 0; b < HIST_BINS; b++) begin
              hist_d[b] = '0;
            end
          end
          default: begin
          end
        endcase
      end

      S_DIV: begin
        if (div_rsp.done) begin
          res_d.mean_value = div_rsp.quotient;
          if (need_below_q) begin
            res_d.element_value = ram_rdata;
            res_d.is_odd        = ram_rdata[0];
            res_d.below_mean    = ram_rdata < div_rsp.quotient;
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      base_q      <= BASE_RESET;
      count_q     <= '0;
      sum_q       <= '0;
      even_q      <= '0;
      odd_q       <= '0;
      min_q       <= MIN_RESET;
      max_q       <= '0;
      for (int b = 0; b < HIST_BINS; b++) begin
        hist_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        base_q <= cfg_i.data;
      end
      count_q <= count_d;
      sum_q   <= sum_d;
      even_q  <= even_d;
      odd_q   <= odd_d;
      min_q   <= min_d;
      max_q   <= max_d;
      hist_q  <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    value_q      <= value_d;
    index_q      <= index_d;
    res_q        <= res_d;
    need_below_q <= need_below_d;
    out_q        <= out_d;
  end

  ssh_ram #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (VAL_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[POS_W-1:0]),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (index_q[POS_W-1:0]),
    .rdata_o (ram_rdata)
  );

  ssh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.stored_position = out_q.stored_position;
  assign out_o.element_value   = out_q.element_value;
  assign out_o.is_odd          = out_q.is_odd;
  assign out_o.below_mean      = out_q.below_mean;
  assign out_o.mean_value      = out_q.mean_value;
  assign out_o.minimum         = out_q.minimum;
  assign out_o.maximum         = out_q.maximum;
  assign out_o.even_total      = out_q.even_total;
  assign out_o.odd_total       = out_q.odd_total;
  assign out_o.sample_total    = out_q.sample_total;
  assign out_o.bin_count       = out_q.bin_count;

endmodule

// File: rtl/ssh_chk.sv
module ssh_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [2:0]              status_i,
  input logic [ssh_pkg::POS_W-1:0] stored_position_i,
  input logic [ssh_pkg::VAL_W-1:0] element_value_i,
  input logic                    is_odd_i,
  input logic                    below_mean_i,
  input logic [ssh_pkg::VAL_W-1:0] mean_value_i,
  input logic [ssh_pkg::CNT_W-1:0] even_total_i,
  input logic [ssh_pkg::CNT_W-1:0] odd_total_i,
  input logic [ssh_pkg::CNT_W-1:0] sample_total_i
);
  import ssh_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted word");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(mean_value_i) && $stable(sample_total_i))
    else $error("stalled result word changed");

  a_full_no_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |->
      (stored_position_i == '0) && !is_odd_i && (sample_total_i == '0))
    else $error("dropped sample carries data");

  a_below_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && below_mean_i |-> element_value_i < mean_value_i)
    else $error("below-mean flag disagrees with mean");

  a_totals_add_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (even_total_i + odd_total_i) == sample_total_i)
    else $error("even and odd totals do not add up");

endmodule

bind sample_statistics_histogram ssh_chk u_ssh_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .stored_position_i (out_o.stored_position),
  .element_value_i   (out_o.element_value),
  .is_odd_i          (out_o.is_odd),
  .below_mean_i      (out_o.below_mean),
  .mean_value_i      (out_o.mean_value),
  .even_total_i      (out_o.even_total),
  .odd_total_i       (out_o.odd_total),
  .sample_total_i    (out_o.sample_total)
);

// File: verif/sample_statistics_histogram_checker.sv
module sample_statistics_histogram_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ssh_in_if    in_mon_i,
  ssh_cfg_if   cfg_mon_i,
  ssh_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  import ssh_pkg::*;

  logic [VAL_W-1:0] base_value;
  logic [VAL_W-1:0] sample_mem [MAX_SAMPLES];
  int unsigned      bin_hits [HIST_BINS];
  int unsigned      sum_q;
  int unsigned      count_q;
  int unsigned      evens_q;
  int unsigned      odds_q;
  logic [VAL_W-1:0] low_q;
  logic [VAL_W-1:0] high_q;
  res_t             stats_due [$];
  res_t             want;
  int               fails = 0;

  function automatic void clear_stats();
    foreach (bin_hits[b]) bin_hits[b] = 0;
    sum_q   = 0;
    count_q = 0;
    evens_q = 0;
    odds_q  = 0;
    low_q   = MIN_RESET;
    high_q  = '0;
  endfunction

  function automatic res_t apply_word(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value,
                                      logic [IDX_W-1:0] index);
    res_t        r;
    int unsigned avg;
    int          offset;
    r      = '0;
    avg    = (count_q == 0) ? 0 : sum_q / count_q;
    offset = int'(value) - int'(base_value);
    case (kind)
      KIND_SAMPLE: begin
        if (count_q >= MAX_SAMPLES) begin
          r.status = ST_FULL;
        end else begin
          sample_mem[count_q] = value;
          r.stored_position   = POS_W'(count_q);
          r.is_odd            = value[0];
          count_q++;
          sum_q += value;
          if (value < low_q) low_q = value;
          if (value > high_q) high_q = value;
          if (value[0]) odds_q++;
          else evens_q++;
          if (offset >= 0 && offset < HIST_BINS) bin_hits[offset]++;
          else r.status = ST_RANGE;
        end
      end
      KIND_SUMMARY: begin
        if (count_q == 0) r.status = ST_EMPTY;
        r.mean_value   = VAL_W'(avg);
        r.minimum      = low_q;
        r.maximum      = high_q;
        r.even_total   = CNT_W'(evens_q);
        r.odd_total    = CNT_W'(odds_q);
        r.sample_total = CNT_W'(count_q);
      end
      KIND_BIN: begin
        if (index >= HIST_BINS) r.status = ST_INDEX;
        else r.bin_count = CNT_W'(bin_hits[index]);
      end
      KIND_ELEMENT: begin
        if (count_q == 0) begin
          r.status = ST_EMPTY;
        end else if (index >= count_q) begin
          r.status = ST_INDEX;
        end else begin
          r.element_value = sample_mem[index];
          r.is_odd        = sample_mem[index][0];
          r.below_mean    = sample_mem[index] < avg;
          r.mean_value    = VAL_W'(avg);
        end
      end
      KIND_CLEAR: clear_stats();
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_value = BASE_RESET;
      clear_stats();
      stats_due.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (stats_due.size() == 0) begin
          $display("%0t result word mismatch: expected none actual status %0d", $time,
                   out_mon_i.status);
          fails++;
        end else begin
          want = stats_due.pop_front();
          check_field("status", want.status, out_mon_i.status);
          check_field("stored_position", want.stored_position, out_mon_i.stored_position);
          check_field("element_value", want.element_value, out_mon_i.element_value);
          check_field("is_odd", want.is_odd, out_mon_i.is_odd);
          check_field("below_mean", want.below_mean, out_mon_i.below_mean);
          check_field("mean_value", want.mean_value, out_mon_i.mean_value);
          check_field("minimum", want.minimum, out_mon_i.minimum);
          check_field("maximum", want.maximum, out_mon_i.maximum);
          check_field("even_total", want.even_total, out_mon_i.even_total);
          check_field("odd_total", want.odd_total, out_mon_i.odd_total);
          check_field("sample_total", want.sample_total, out_mon_i.sample_total);
          check_field("bin_count", want.bin_count, out_mon_i.bin_count);
        end
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) base_value = cfg_mon_i.data;
      if (in_mon_i.valid && in_mon_i.ready)
        stats_due.push_back(apply_word(in_mon_i.kind, in_mon_i.value, in_mon_i.index));
    end
    fail_count_o <= fails;
    pending_o    <= stats_due.size();
  end

endmodule

// File: verif/sample_statistics_histogram_tb.sv
module sample_statistics_histogram_tb;
  import ssh_pkg::*;

  localparam int LIMIT   = 1_000_000;
  localparam int SETTLE  = 25;
  localparam int VAL_MAX = (1 << VAL_W) - 1;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  int               cycles    = 0;
  int               fails;
  int               pending;
  int unsigned      fill      = 0;
  logic [VAL_W-1:0] base_now  = BASE_RESET;

  ssh_in_if  in_w ();
  ssh_cfg_if cfg_w ();
  ssh_out_if out_w ();

  sample_statistics_histogram uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .cfg_i  (cfg_w),
    .out_o  (out_w)
  );

  sample_statistics_histogram_checker stats_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_w),
    .cfg_mon_i    (cfg_w),
    .out_mon_i    (out_w),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_w.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold valid high across back-to-back words; drop it only for a gap
  task automatic send_word(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value,
                           logic [IDX_W-1:0] index);
    while ($urandom_range(99) < idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    in_w.kind  <= kind;
    in_w.value <= value;
    in_w.index <= index;
    if (kind == KIND_SAMPLE && fill < MAX_SAMPLES) fill++;
    else if (kind == KIND_CLEAR) fill = 0;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(logic [VAL_W-1:0] v);
    drain();
    cfg_w.valid <= 1'b1;
    cfg_w.data  <= v;
    do @(posedge clk_i); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
    base_now = v;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int span;
    span = VAL_MAX - int'(base_now);
    if (span > HIST_BINS - 1) span = HIST_BINS - 1;
    if ($urandom_range(1)) return VAL_W'(int'(base_now) + $urandom_range(span));
    return VAL_W'($urandom_range(VAL_MAX));
  endfunction

  function automatic logic [IDX_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(9);
    if (fill != 0 && roll < 7) return IDX_W'($urandom_range(fill - 1));
    if (roll == 7) return IDX_W'(fill);
    return IDX_W'($urandom_range(IDX_MAX));
  endfunction

  task automatic random_ops(int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 50)
        send_word(KIND_SAMPLE, pick_value(), IDX_W'($urandom_range(IDX_MAX)));
      else if (roll < 60)
        send_word(KIND_SUMMARY, VAL_W'($urandom), IDX_W'($urandom));
      else if (roll < 72)
        send_word(KIND_BIN, VAL_W'($urandom), ($urandom_range(4) != 0) ?
                  IDX_W'($urandom_range(HIST_BINS - 1)) : IDX_W'($urandom_range(IDX_MAX)));
      else if (roll < 92)
        send_word(KIND_ELEMENT, VAL_W'($urandom), pick_position());
      else if (roll < 96)
        send_word(KIND_CLEAR, VAL_W'($urandom), IDX_W'($urandom));
      else
        send_word(KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)), VAL_W'($urandom),
                  IDX_W'($urandom));
    end
  endtask

  initial begin
    in_w.valid  <= 1'b0;
    in_w.kind   <= KIND_SAMPLE;
    in_w.value  <= '0;
    in_w.index  <= '0;
    cfg_w.valid <= 1'b0;
    cfg_w.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(KIND_SUMMARY, VAL_W'(VAL_MAX), IDX_W'(IDX_MAX));
    send_word(KIND_ELEMENT, 0, 0);
    send_word(KIND_BIN, 0, 0);
    send_word(KIND_BIN, 0, IDX_W'(HIST_BINS));
    send_word(KIND_BIN, 0, IDX_W'(IDX_MAX));
    send_word(KIND_SAMPLE, BASE_RESET, 0);
    send_word(KIND_SAMPLE, VAL_W'(BASE_RESET + HIST_BINS - 1), IDX_W'(IDX_MAX));
    send_word(KIND_SAMPLE, VAL_W'(BASE_RESET + HIST_BINS), 0);
    send_word(KIND_SAMPLE, VAL_W'(BASE_RESET - 1), 0);
    send_word(KIND_SAMPLE, 0, 0);
    send_word(KIND_SAMPLE, VAL_W'(VAL_MAX), 0);
    send_word(KIND_SUMMARY, 0, 0);
    send_word(KIND_ELEMENT, 0, 0);
    send_word(KIND_ELEMENT, 0, 5);
    send_word(KIND_ELEMENT, 0, 6);
    send_word(KIND_ELEMENT, 0, IDX_W'(IDX_MAX));
    send_word(KIND_BIN, 0, 0);
    send_word(KIND_BIN, 0, IDX_W'(HIST_BINS - 1));
    send_word(KIND_SPARE_LO, VAL_W'(VAL_MAX), IDX_W'(IDX_MAX));
    send_word(KIND_SPARE_HI, 0, 0);
    send_word(KIND_CLEAR, 0, 0);
    send_word(KIND_SUMMARY, 0, 0);
    send_word(KIND_BIN, 0, 0);
    send_word(KIND_SAMPLE, 20, 0);
    send_word(KIND_SAMPLE, 30, 0);
    send_word(KIND_SAMPLE, 40, 0);
    send_word(KIND_ELEMENT, 0, 1);

    random_ops(290);

    idle_pct = 69;
    write_base(0);
    random_ops(320);

    idle_pct  = 0;
    stall_pct = 69;
    write_base(VAL_W'(VAL_MAX));
    send_word(KIND_CLEAR, 0, 0);
    while (fill < MAX_SAMPLES)
      send_word(KIND_SAMPLE, pick_value(), IDX_W'($urandom_range(IDX_MAX)));
    repeat (3) send_word(KIND_SAMPLE, pick_value(), IDX_W'($urandom_range(IDX_MAX)));
    send_word(KIND_SUMMARY, 0, 0);
    send_word(KIND_ELEMENT, 0, IDX_W'(IDX_MAX));
    send_word(KIND_ELEMENT, 0, 0);
    send_word(KIND_BIN, 0, 0);
    random_ops(100);

    idle_pct  = 36;
    stall_pct = 36;
    write_base(VAL_W'($urandom_range(VAL_MAX)));
    random_ops(300);

    idle_pct  = 0;
    stall_pct = 0;
    write_base(VAL_W'(VAL_MAX + 1 - HIST_BINS));
    random_ops(80);

    drain();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssh_pkg.sv
rtl/ssh_if.sv
rtl/ssh_ram.sv
rtl/ssh_div.sv
rtl/sample_statistics_histogram.sv
rtl/ssh_chk.sv
verif/sample_statistics_histogram_checker.sv
verif/sample_statistics_histogram_tb.sv
